[hdl/rpsp_pkg.sv]
// ----------------------------------------------------------------------------
// Radio packet stream parser package
// Shared widths, register indexes, event codes, header layout and the
// configuration register bundle.
// ----------------------------------------------------------------------------
package rpsp_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W     = 10;

    localparam int HEADER_BYTES_DEF = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_CTRL       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_COMMAND    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CTRL_LENGTH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHUNK_LEN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_FRAME       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CHUNK_COUNT = 3'd6;

    localparam logic [2:0] EV_DISCARD   = 3'd0;
    localparam logic [2:0] EV_STORED    = 3'd1;
    localparam logic [2:0] EV_AUDIO_OK  = 3'd2;
    localparam logic [2:0] EV_AUDIO_BAD = 3'd3;
    localparam logic [2:0] EV_CTRL_OK   = 3'd4;
    localparam logic [2:0] EV_CTRL_BAD  = 3'd5;
    localparam logic [2:0] EV_HDR_REJ   = 3'd6;

    localparam logic [7:0] AUDIO_SELECT = 8'h5E;
    localparam logic [7:0] AUDIO_SYNC   = 8'hE5;

    localparam logic [COUNT_W-1:0] POS_CTRL_CMD    = 10'd2;
    localparam logic [COUNT_W-1:0] POS_CTRL_ARG    = 10'd3;
    localparam logic [COUNT_W-1:0] POS_CHUNK_IDX   = 10'd3;
    localparam logic [COUNT_W-1:0] POS_CHUNK_COUNT = 10'd4;
    localparam logic [COUNT_W-1:0] POS_FRAME_LO    = 10'd5;
    localparam logic [COUNT_W-1:0] POS_FRAME_HI    = 10'd6;
    localparam logic [COUNT_W-1:0] POS_OFFSET_LO   = 10'd7;
    localparam logic [COUNT_W-1:0] POS_OFFSET_HI   = 10'd8;
    localparam logic [COUNT_W-1:0] POS_PAYLOAD_LO  = 10'd9;
    localparam logic [COUNT_W-1:0] POS_PAYLOAD_HI  = 10'd10;

    localparam logic [16:0] MAX_PACKET = 17'd1023;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_ctrl;
        logic [7:0]  ctrl_command;
        logic [4:0]  ctrl_length;
        logic [9:0]  max_chunk_len;
        logic [15:0] max_frame;
        logic [7:0]  max_chunk_count;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        sync_first:      8'hE5,
        sync_ctrl:       8'hC0,
        ctrl_command:    8'd1,
        ctrl_length:     5'd4,
        max_chunk_len:   10'd200,
        max_frame:       16'd2000,
        max_chunk_count: 8'd16
    };

endpackage

[hdl/rpsp_cfg.sv]
// ----------------------------------------------------------------------------
// Radio packet stream parser configuration registers
// Write-only register file; values are truncated to each register's width.
// ----------------------------------------------------------------------------
module rpsp_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rpsp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rpsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rpsp_pkg::t_cfg                   o_cfg
);

    rpsp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= rpsp_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpsp_pkg::REG_SYNC_FIRST: begin
                    r_cfg.sync_first <= i_cfg_data[7:0];
                end
                rpsp_pkg::REG_SYNC_CTRL: begin
                    r_cfg.sync_ctrl <= i_cfg_data[7:0];
                end
                rpsp_pkg::REG_CTRL_COMMAND: begin
                    r_cfg.ctrl_command <= i_cfg_data[7:0];
                end
                rpsp_pkg::REG_CTRL_LENGTH: begin
                    r_cfg.ctrl_length <= i_cfg_data[4:0];
                end
                rpsp_pkg::REG_MAX_CHUNK_LEN: begin
                    r_cfg.max_chunk_len <= i_cfg_data[9:0];
                end
                rpsp_pkg::REG_MAX_FRAME: begin
                    r_cfg.max_frame <= i_cfg_data[15:0];
                end
                rpsp_pkg::REG_MAX_CHUNK_COUNT: begin
                    r_cfg.max_chunk_count <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/rpsp_parse.sv]
// ----------------------------------------------------------------------------
// Radio packet stream parser core
// Packet state machine, header capture and checks, and the result register.
// ----------------------------------------------------------------------------
module rpsp_parse #(
    parameter int HEADER_BYTES = rpsp_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rpsp_pkg::t_cfg               i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [7:0]                   i_byte_in,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [7:0]                   o_byte_out,
    output logic [rpsp_pkg::COUNT_W-1:0] o_position,
    output logic [2:0]                   o_event_res,
    output logic [rpsp_pkg::COUNT_W-1:0] o_packet_length
);

    localparam int CW = rpsp_pkg::COUNT_W;
    localparam logic [CW-1:0] HB = CW'(HEADER_BYTES);
    localparam logic [16:0] HB17 = 17'(HEADER_BYTES);

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_HEAD  = 3'd2,
        PH_AUDIO = 3'd3,
        PH_CTRL  = 3'd4
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [CW-1:0]  r_count, n_count;
    logic [7:0]     r_chunk_idx, n_chunk_idx;
    logic [7:0]     r_chunk_count, n_chunk_count;
    logic [15:0]    r_frame, n_frame;
    logic [15:0]    r_offset, n_offset;
    logic [15:0]    r_payload, n_payload;
    logic [7:0]     r_cmd, n_cmd;
    logic [7:0]     r_arg, n_arg;

    logic           r_out_valid;
    logic [7:0]     r_byte;
    logic [CW-1:0]  r_pos, n_pos;
    logic [2:0]     r_ev, n_ev;
    logic [CW-1:0]  r_plen, n_plen;

    logic           accept;
    logic [CW-1:0]  count_inc;
    logic           audio_ok;
    logic           ctrl_ok;

    function automatic logic header_good(input rpsp_pkg::t_cfg cfg, input logic [15:0] frame,
                                         input logic [15:0] offset,
                                         input logic [15:0] payload);
        logic ok;
        ok = (payload != 16'd0) && (payload <= {6'd0, cfg.max_chunk_len}) &&
             (frame != 16'd0) && (frame <= cfg.max_frame) &&
             (({1'b0, offset} + {1'b0, payload}) <= {1'b0, frame});
        return ok;
    endfunction

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign count_inc  = r_count + 1'b1;

    assign audio_ok = header_good(i_cfg, r_frame, r_offset, r_payload) &&
                      (r_chunk_count != 8'd0) &&
                      (r_chunk_count <= i_cfg.max_chunk_count) &&
                      (r_chunk_idx < r_chunk_count) &&
                      (i_cfg.sync_first == rpsp_pkg::AUDIO_SYNC);

    always_comb begin
        n_phase       = r_phase;
        n_count       = r_count;
        n_chunk_idx   = r_chunk_idx;
        n_chunk_count = r_chunk_count;
        n_frame       = r_frame;
        n_offset      = r_offset;
        n_payload     = r_payload;
        n_cmd         = r_cmd;
        n_arg         = r_arg;
        n_pos         = '0;
        n_ev          = rpsp_pkg::EV_DISCARD;
        n_plen        = '0;
        ctrl_ok       = 1'b0;
        case (r_phase)
            PH_SYNC2: begin
                if (i_byte_in == rpsp_pkg::AUDIO_SELECT) begin
                    n_pos   = CW'(1);
                    n_ev    = rpsp_pkg::EV_STORED;
                    n_count = CW'(2);
                    n_phase = PH_HEAD;
                end else if (i_byte_in == i_cfg.sync_ctrl) begin
                    n_pos   = CW'(1);
                    n_ev    = rpsp_pkg::EV_STORED;
                    n_count = CW'(2);
                    n_phase = PH_CTRL;
                    n_cmd   = 8'd0;
                    n_arg   = 8'd0;
                end else if (i_byte_in == i_cfg.sync_first) begin
                    n_ev    = rpsp_pkg::EV_STORED;
                    n_count = CW'(1);
                end else begin
                    n_phase = PH_SYNC1;
                    n_count = '0;
                end
            end
            PH_HEAD: begin
                n_pos   = r_count;
                n_ev    = rpsp_pkg::EV_STORED;
                n_count = count_inc;
                case (r_count)
                    rpsp_pkg::POS_CHUNK_IDX:   n_chunk_idx     = i_byte_in;
                    rpsp_pkg::POS_CHUNK_COUNT: n_chunk_count   = i_byte_in;
                    rpsp_pkg::POS_FRAME_LO:    n_frame[7:0]    = i_byte_in;
                    rpsp_pkg::POS_FRAME_HI:    n_frame[15:8]   = i_byte_in;
                    rpsp_pkg::POS_OFFSET_LO:   n_offset[7:0]   = i_byte_in;
                    rpsp_pkg::POS_OFFSET_HI:   n_offset[15:8]  = i_byte_in;
                    rpsp_pkg::POS_PAYLOAD_LO:  n_payload[7:0]  = i_byte_in;
                    rpsp_pkg::POS_PAYLOAD_HI:  n_payload[15:8] = i_byte_in;
                    default: begin
                    end
                endcase
                if (count_inc >= HB) begin
                    if (!header_good(i_cfg, n_frame, n_offset, n_payload) ||
                        (HB17 + {1'b0, n_payload}) > rpsp_pkg::MAX_PACKET) begin
                        n_ev    = rpsp_pkg::EV_HDR_REJ;
                        n_phase = PH_SYNC1;
                        n_count = '0;
                    end else begin
                        n_phase = PH_AUDIO;
                    end
                end
            end
            PH_AUDIO: begin
                n_pos   = r_count;
                n_ev    = rpsp_pkg::EV_STORED;
                n_count = count_inc;
                if ({7'd0, count_inc} >= (HB17 + {1'b0, r_payload})) begin
                    n_ev    = audio_ok ? rpsp_pkg::EV_AUDIO_OK : rpsp_pkg::EV_AUDIO_BAD;
                    n_plen  = count_inc;
                    n_phase = PH_SYNC1;
                    n_count = '0;
                end
            end
            PH_CTRL: begin
                n_pos   = r_count;
                n_ev    = rpsp_pkg::EV_STORED;
                n_count = count_inc;
                if (r_count == rpsp_pkg::POS_CTRL_CMD) begin
                    n_cmd = i_byte_in;
                end else if (r_count == rpsp_pkg::POS_CTRL_ARG) begin
                    n_arg = i_byte_in;
                end
                ctrl_ok = (count_inc == {5'd0, i_cfg.ctrl_length}) &&
                          (n_cmd == i_cfg.ctrl_command) && (n_arg <= 8'd1);
                if (count_inc >= {5'd0, i_cfg.ctrl_length}) begin
                    n_ev    = ctrl_ok ? rpsp_pkg::EV_CTRL_OK : rpsp_pkg::EV_CTRL_BAD;
                    n_plen  = count_inc;
                    n_phase = PH_SYNC1;
                    n_count = '0;
                end
            end
            default: begin
                if (i_byte_in == i_cfg.sync_first) begin
                    n_ev    = rpsp_pkg::EV_STORED;
                    n_count = CW'(1);
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_SYNC1;
                    n_count = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SYNC1;
            r_count       <= '0;
            r_chunk_idx   <= '0;
            r_chunk_count <= '0;
            r_frame       <= '0;
            r_offset      <= '0;
            r_payload     <= '0;
            r_cmd         <= '0;
            r_arg         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase       <= n_phase;
                r_count       <= n_count;
                r_chunk_idx   <= n_chunk_idx;
                r_chunk_count <= n_chunk_count;
                r_frame       <= n_frame;
                r_offset      <= n_offset;
                r_payload     <= n_payload;
                r_cmd         <= n_cmd;
                r_arg         <= n_arg;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_byte_in;
            r_pos  <= n_pos;
            r_ev   <= n_ev;
            r_plen <= n_plen;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_out      = r_byte;
    assign o_position      = r_pos;
    assign o_event_res     = r_ev;
    assign o_packet_length = r_plen;

endmodule

[hdl/radio_packet_stream_parser.sv]
// ----------------------------------------------------------------------------
// Radio packet stream parser
// Sync hunt, audio and control packet framing, header checks and end-of-packet
// send verdicts over a serial byte stream.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle unless i_out_stall holds a full
// result register, and returns exactly one result beat per byte, in the cycle
// after the byte is accepted; the rate is set by the single result register,
// which refills in the cycle it is drained, so a byte is accepted whenever the
// result register is empty or being taken. Configuration registers come up at
// their documented defaults and need no initialization pass.
module radio_packet_stream_parser #(
    parameter int HEADER_BYTES = rpsp_pkg::HEADER_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rpsp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rpsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_byte_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_byte_out,
    output logic [rpsp_pkg::COUNT_W-1:0]     o_position,
    output logic [2:0]                       o_event_res,
    output logic [rpsp_pkg::COUNT_W-1:0]     o_packet_length
);

    rpsp_pkg::t_cfg cfg;

    rpsp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rpsp_parse #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_byte_in       (i_byte_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_byte_out      (o_byte_out),
        .o_position      (o_position),
        .o_event_res     (o_event_res),
        .o_packet_length (o_packet_length)
    );

endmodule

[hdl/rpsp_checker.sv]
// ----------------------------------------------------------------------------
// Radio packet stream parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module rpsp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [7:0]                       i_byte_in,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [7:0]                       o_byte_out,
    input logic [rpsp_pkg::COUNT_W-1:0]     o_position,
    input logic [2:0]                       o_event_res,
    input logic [rpsp_pkg::COUNT_W-1:0]     o_packet_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_byte_out) &&
        $stable(o_event_res))
        else $error("Stalled result beat changed.");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid && (o_byte_out == $past(i_byte_in)))
        else $error("Accepted byte did not produce a result beat.");

    a_plen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !(o_event_res == rpsp_pkg::EV_AUDIO_OK ||
        o_event_res == rpsp_pkg::EV_AUDIO_BAD || o_event_res == rpsp_pkg::EV_CTRL_OK ||
        o_event_res == rpsp_pkg::EV_CTRL_BAD) |-> o_packet_length == '0)
        else $error("Packet length reported without a completion event.");

    a_discard_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == rpsp_pkg::EV_DISCARD) |-> o_position == '0)
        else $error("Discarded byte carries a nonzero position.");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("Input stalled while the result register could take a beat.");

endmodule

bind radio_packet_stream_parser rpsp_checker u_rpsp_checker (.*);
